// ===== rtl/kvbt_pkg.sv =====
// shared types and constants for the paged key/value block table
`default_nettype none
package kvbt_pkg;

  localparam int MAX_SEQS           = 8;
  localparam int MAX_HEADS          = 8;
  localparam int MAX_LOGICAL_BLOCKS = 64;
  localparam int PHYS_BLOCKS        = 4096;
  localparam int BLOCK_SHIFT        = 7;
  localparam int BLOCK_TOKENS       = 1 << BLOCK_SHIFT;

  localparam int SEQ_W  = 3;
  localparam int HEAD_W = 3;
  localparam int LB_W   = 6;
  localparam int LBC_W  = LB_W + 1;
  localparam int PA_W   = 12;
  localparam int TOP_W  = PA_W + 1;
  localparam int LEN_W  = 14;
  localparam int TOK_W  = 8;
  localparam int CNT_W  = 4;
  localparam int TA_W   = SEQ_W + HEAD_W + LB_W;
  localparam int LEN_LIMIT = MAX_LOGICAL_BLOCKS * BLOCK_TOKENS;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_GATHER = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_BLOCKS = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] REG_SEQS  = 2'd0;
  localparam logic [1:0] REG_HEADS = 2'd1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_CHK, S_A_POP, S_A_WR, S_F_EXE, S_G_CHK, S_G_SCAN, S_G_EMIT
  } state_e;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [PA_W-1:0] data;
  } stack_req_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       status;
    logic [PA_W-1:0]  phys;
    logic [LB_W-1:0]  logical;
    logic [TOK_W-1:0] tokens;
    logic             entry_valid;
    logic [TOP_W-1:0] fcnt;
    logic             last;
  } emit_t;

endpackage
`default_nettype wire

// ===== rtl/kvbt_free_stack.sv =====
// lifo stack of free physical block ids with a fill pass after reset
`default_nettype none
module kvbt_free_stack
  import kvbt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire stack_req_t       req_i,
  output logic [TOP_W-1:0]      top_o,
  output logic [PA_W-1:0]       rd_data_o,
  output logic                  ready_o
);

  logic [PA_W-1:0]  mem [PHYS_BLOCKS];
  logic [TOP_W-1:0] top_q, top_d;
  logic [TOP_W-1:0] fill_q, fill_d;
  logic [PA_W-1:0]  rd_q;
  logic             filling;

  assign filling = (fill_q != TOP_W'(PHYS_BLOCKS));

  always_comb begin
    fill_d = filling ? fill_q + TOP_W'(1) : fill_q;
    top_d  = top_q;
    if (!filling && req_i.push) begin
      top_d = top_q + TOP_W'(1);
    end else if (!filling && req_i.pop) begin
      top_d = top_q - TOP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= TOP_W'(PHYS_BLOCKS);
      fill_q <= '0;
    end else begin
      top_q  <= top_d;
      fill_q <= fill_d;
    end
  end

  // one write port, one read port
  always_ff @(posedge clk_i) begin
    if (filling) begin
      mem[fill_q[PA_W-1:0]] <= fill_q[PA_W-1:0];
    end else if (req_i.push) begin
      mem[top_q[PA_W-1:0]] <= req_i.data;
    end
    if (req_i.pop) begin
      rd_q <= mem[top_d[PA_W-1:0]];
    end
  end

  assign top_o     = top_q;
  assign rd_data_o = rd_q;
  assign ready_o   = !filling;

endmodule
`default_nettype wire

// ===== rtl/paged_kv_block_table.sv =====
// paged key/value block table: sequencer, length registers and page table
// free and unknown commands: one result, set in state S_F_EXE and registered onto the outputs; busy in S_F_EXE
// append: a check state S_A_CHK, then S_A_POP and S_A_WR for each popped id (new blocks times active heads)
// gather: a check state S_G_CHK, then S_G_SCAN per block index up to the last masked one, and S_G_EMIT per entry
// each popped id is read from the stack before it is written to the page table, hence two states per id
// after reset the free stack is filled, one id a cycle, and busy stays high in S_INIT until the fill is done
// results cannot be stalled: each is shown for one cycle with result_valid_o
`default_nettype none
module paged_kv_block_table
  import kvbt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [SEQ_W-1:0]  sequence_req_i,
  input  wire logic [HEAD_W-1:0] head_i,
  input  wire logic [LEN_W-1:0]  new_tokens_i,
  input  wire logic [63:0]       block_mask_i,
  input  wire logic [PA_W-1:0]   free_id_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic [PA_W-1:0]        phys_block_o,
  output logic [LB_W-1:0]        logical_block_o,
  output logic [TOK_W-1:0]       block_fill_o,
  output logic                   entry_valid_o,
  output logic [TOP_W-1:0]       free_count_o,
  output logic                   last_o
);

  state_e state_q, state_d;
  emit_t  emit;
  stack_req_t sreq;
  logic [TOP_W-1:0] top;
  logic [PA_W-1:0]  stack_rd;
  logic             stack_ready;

  logic [CNT_W-1:0] seqs_cfg_q, heads_cfg_q, seqs, heads;
  logic [LEN_W-1:0] seq_len_q [MAX_SEQS];

  logic [1:0]        cmd_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [HEAD_W-1:0] head_q;
  logic [LEN_W-1:0]  tokens_q;
  logic [63:0]       mask_q, eff_q;
  logic [PA_W-1:0]   id_q;
  logic [LBC_W-1:0]  k_q, b1_q;
  logic [HEAD_W-1:0] h_q;
  logic [LB_W-1:0]   i_q;
  logic [LEN_W-1:0]  len_q;

  logic [PA_W-1:0] tbl [1 << TA_W];
  logic [PA_W-1:0] tbl_rd_q;
  logic            tbl_we, tbl_re, len_we;

  logic             accept, seq_ok, head_ok, too_long, short, id_bad;
  logic [LEN_W-1:0] old_len;
  logic [LEN_W:0]   new_len;
  logic [LBC_W-1:0] b0, b1, nblk;
  logic [LBC_W+CNT_W-1:0] need;
  logic [63:0]      lowmask, eff_init, eff_rest;
  logic             pop_last, g_last;
  logic [LEN_W-1:0] rest;
  logic [TOK_W-1:0] tok;

  kvbt_free_stack u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sreq),
    .top_o    (top),
    .rd_data_o(stack_rd),
    .ready_o  (stack_ready)
  );

  function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W-1:0] v, input int mx);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(mx)) r = CNT_W'(mx);
    return r;
  endfunction

  assign seqs  = clamp(seqs_cfg_q, MAX_SEQS);
  assign heads = clamp(heads_cfg_q, MAX_HEADS);

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // checks and block arithmetic on the latched transaction
  assign seq_ok   = ({1'b0, seq_q} < seqs);
  assign head_ok  = ({1'b0, head_q} < heads);
  assign old_len  = seq_len_q[seq_q];
  assign new_len  = {1'b0, old_len} + {1'b0, tokens_q};
  assign too_long = (new_len > (LEN_W+1)'(LEN_LIMIT));
  assign b0 = LBC_W'(({1'b0, old_len} + (LEN_W+1)'(BLOCK_TOKENS - 1)) >> BLOCK_SHIFT);
  assign b1 = LBC_W'((new_len + (LEN_W+1)'(BLOCK_TOKENS - 1)) >> BLOCK_SHIFT);
  assign need  = (b1 - b0) * heads;
  assign short = ({{(TOP_W-LBC_W-CNT_W){1'b0}}, need} > top);
  assign id_bad = ({1'b0, id_q} >= TOP_W'(PHYS_BLOCKS));
  assign nblk  = (b0 > LBC_W'(MAX_LOGICAL_BLOCKS)) ? LBC_W'(MAX_LOGICAL_BLOCKS) : b0;
  assign lowmask  = (nblk >= LBC_W'(64)) ? '1 : ((64'd1 << nblk[LB_W-1:0]) - 64'd1);
  assign eff_init = mask_q & lowmask;
  assign pop_last = (h_q == HEAD_W'(heads - CNT_W'(1))) && (k_q == b1_q - LBC_W'(1));
  assign eff_rest = eff_q & ~(64'd1 << i_q);
  assign g_last   = (eff_rest == '0);
  assign rest     = len_q - LEN_W'({i_q, {BLOCK_SHIFT{1'b0}}});
  assign tok      = (rest > LEN_W'(BLOCK_TOKENS)) ? TOK_W'(BLOCK_TOKENS) : rest[TOK_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: if (stack_ready) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_APPEND: state_d = S_A_CHK;
            CMD_GATHER: state_d = S_G_CHK;
            default:    state_d = S_F_EXE;
          endcase
        end
      end
      S_A_CHK: begin
        if (seq_ok && !too_long && !short && b0 != b1) state_d = S_A_POP;
        else state_d = S_IDLE;
      end
      S_A_POP:  state_d = S_A_WR;
      S_A_WR:   state_d = pop_last ? S_IDLE : S_A_POP;
      S_F_EXE:  state_d = S_IDLE;
      S_G_CHK: begin
        if (seq_ok && head_ok && eff_init != '0) state_d = S_G_SCAN;
        else state_d = S_IDLE;
      end
      S_G_SCAN: if (eff_q[i_q]) state_d = S_G_EMIT;
      S_G_EMIT: state_d = g_last ? S_IDLE : S_G_SCAN;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    emit   = '0;
    emit.fcnt = top;
    emit.last = 1'b1;
    sreq   = '0;
    sreq.data = id_q;
    tbl_we = 1'b0;
    tbl_re = 1'b0;
    len_we = 1'b0;
    unique case (state_q)
      S_A_CHK: begin
        emit.valid = 1'b1;
        priority if (!seq_ok) emit.status = ST_BAD_INDEX;
        else if (too_long) emit.status = ST_TOO_LONG;
        else if (short) emit.status = ST_NO_BLOCKS;
        else if (b0 == b1) begin
          emit.status = ST_OK;
          len_we = 1'b1;
        end else emit.valid = 1'b0;
      end
      S_A_POP: sreq.pop = 1'b1;
      S_A_WR: begin
        tbl_we = 1'b1;
        if (pop_last) begin
          emit.valid = 1'b1;
          emit.status = ST_OK;
          len_we = 1'b1;
        end
      end
      S_F_EXE: begin
        emit.valid = 1'b1;
        priority if (cmd_q != CMD_FREE || id_bad) emit.status = ST_BAD_INDEX;
        else if (top == TOP_W'(PHYS_BLOCKS)) emit.status = ST_FULL;
        else begin
          emit.status = ST_OK;
          sreq.push = 1'b1;
          emit.fcnt = top + TOP_W'(1);
        end
      end
      S_G_CHK: begin
        if (!(seq_ok && head_ok)) begin
          emit.valid = 1'b1;
          emit.status = ST_BAD_INDEX;
        end else if (eff_init == '0) begin
          emit.valid = 1'b1;
          emit.status = ST_OK;
        end
      end
      S_G_SCAN: tbl_re = eff_q[i_q];
      S_G_EMIT: begin
        emit.valid = 1'b1;
        emit.status = ST_OK;
        emit.phys = tbl_rd_q;
        emit.logical = i_q;
        emit.tokens = tok;
        emit.entry_valid = 1'b1;
        emit.last = g_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      seqs_cfg_q     <= CNT_W'(MAX_SEQS);
      heads_cfg_q    <= CNT_W'(MAX_HEADS);
      result_valid_o <= 1'b0;
      for (int s = 0; s < MAX_SEQS; s++) seq_len_q[s] <= '0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= emit.valid;
      if (cfg_valid_i && cfg_index_i == REG_SEQS) seqs_cfg_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == REG_HEADS) heads_cfg_q <= cfg_data_i;
      if (len_we) seq_len_q[seq_q] <= new_len[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      seq_q    <= sequence_req_i;
      head_q   <= head_i;
      tokens_q <= new_tokens_i;
      mask_q   <= block_mask_i;
      id_q     <= free_id_i;
    end
    if (state_q == S_A_CHK) begin
      k_q  <= b0;
      b1_q <= b1;
      h_q  <= '0;
    end
    if (state_q == S_A_WR) begin
      if (h_q == HEAD_W'(heads - CNT_W'(1))) begin
        h_q <= '0;
        k_q <= k_q + LBC_W'(1);
      end else begin
        h_q <= h_q + HEAD_W'(1);
      end
    end
    if (state_q == S_G_CHK) begin
      eff_q <= eff_init;
      i_q   <= '0;
      len_q <= old_len;
    end
    if (state_q == S_G_SCAN && !eff_q[i_q]) i_q <= i_q + LB_W'(1);
    if (state_q == S_G_EMIT) begin
      eff_q <= eff_rest;
      i_q   <= i_q + LB_W'(1);
    end
    if (emit.valid) begin
      status_o          <= emit.status;
      phys_block_o      <= emit.phys;
      logical_block_o   <= emit.logical;
      block_fill_o      <= emit.tokens;
      entry_valid_o     <= emit.entry_valid;
      free_count_o      <= emit.fcnt;
      last_o            <= emit.last;
    end
  end

  // page table memory, undefined until written
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl[{seq_q, h_q, k_q[LB_W-1:0]}] <= stack_rd;
    if (tbl_re) tbl_rd_q <= tbl[{seq_q, head_q, i_q}];
  end

endmodule
`default_nettype wire

// ===== bench/paged_kv_block_table_tb.sv =====
// testbench for the paged key/value block table: queued command driver, result monitor, predictor
`default_nettype none
module paged_kv_block_table_tb;
  import kvbt_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  seq;
    logic [2:0]  head;
    logic [13:0] tokens;
    logic [63:0] mask;
    logic [11:0] fid;
  } command_t;

  typedef struct {
    logic [2:0]  status;
    logic [11:0] phys;
    logic [5:0]  logical;
    logic [7:0]  tokens;
    logic        entry_valid;
    logic [12:0] fcnt;
    logic        last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  cmd_i = CMD_APPEND;
  logic [2:0]  sequence_req_i = '0;
  logic [2:0]  head_i = '0;
  logic [13:0] new_tokens_i = '0;
  logic [63:0] block_mask_i = '0;
  logic [11:0] free_id_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_SEQS;
  logic [3:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [2:0]  status_o;
  logic [11:0] phys_block_o;
  logic [5:0]  logical_block_o;
  logic [7:0]  block_fill_o;
  logic        entry_valid_o;
  logic [12:0] free_count_o;
  logic        last_o;

  paged_kv_block_table dut (.*);

  always #6 clk_i = ~clk_i;

  command_t cmd_queue[$];
  answer_t  pending_answers[$];
  int errors = 0;
  logic taken = 1'b0;
  int gap = 0;

  // predictor state
  logic [3:0]  cfg_seqs = 4'd8, cfg_heads = 4'd8;
  int unsigned seq_len[MAX_SEQS];
  logic [11:0] page_tbl[MAX_SEQS][MAX_HEADS][MAX_LOGICAL_BLOCKS];
  logic [11:0] free_stk[PHYS_BLOCKS];
  int unsigned free_top = PHYS_BLOCKS;

  // stimulus-side view: lowest head count seen by appends per sequence
  int min_heads[MAX_SEQS];
  int gen_heads = 8, gen_seqs = 8;

  function automatic int unsigned eff(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  task automatic push_answer(logic [2:0] st, logic [11:0] ph, logic [5:0] lb,
                             logic [7:0] tk, logic ev, logic lst);
    answer_t a;
    a.status = st; a.phys = ph; a.logical = lb; a.tokens = tk;
    a.entry_valid = ev; a.fcnt = free_top[12:0]; a.last = lst;
    pending_answers = {pending_answers, a};
  endtask

  task automatic predict_command(command_t c);
    int unsigned seqs, heads, len, nlen, b0, b1, n, rest;
    logic [2:0] st;
    seqs = eff(cfg_seqs);
    heads = eff(cfg_heads);
    st = ST_OK;
    n = 0;
    if (c.cmd == CMD_GATHER) begin
      if (c.seq >= seqs || c.head >= heads) begin
        push_answer(ST_BAD_INDEX, 0, 0, 0, 0, 1);
      end else begin
        len = seq_len[c.seq];
        b1 = (len + BLOCK_TOKENS - 1) / BLOCK_TOKENS;
        for (int i = 0; i < b1 && i < 64; i++) begin
          if (c.mask[i]) begin
            rest = len - i * BLOCK_TOKENS;
            if (n > 0) pending_answers[$].last = 1'b0;
            push_answer(ST_OK, page_tbl[c.seq][c.head][i], i[5:0],
                        rest < BLOCK_TOKENS ? rest[7:0] : 8'd128, 1, 1);
            n++;
          end
        end
        if (n == 0) push_answer(ST_OK, 0, 0, 0, 0, 1);
      end
    end else begin
      if (c.cmd == CMD_APPEND) begin
        len = seq_len[c.seq];
        nlen = len + c.tokens;
        b0 = (len + BLOCK_TOKENS - 1) / BLOCK_TOKENS;
        b1 = (nlen + BLOCK_TOKENS - 1) / BLOCK_TOKENS;
        if (c.seq >= seqs) st = ST_BAD_INDEX;
        else if (nlen > LEN_LIMIT) st = ST_TOO_LONG;
        else if ((b1 - b0) * heads > free_top) st = ST_NO_BLOCKS;
        else begin
          for (int k = b0; k < b1; k++)
            for (int h = 0; h < heads; h++) begin
              free_top--;
              page_tbl[c.seq][h][k] = free_stk[free_top];
            end
          seq_len[c.seq] = nlen;
        end
      end else if (c.cmd == CMD_FREE) begin
        if (free_top >= PHYS_BLOCKS) st = ST_FULL;
        else begin
          free_stk[free_top] = c.fid;
          free_top++;
        end
      end else begin
        st = ST_BAD_INDEX;
      end
      push_answer(st, 0, 0, 0, 0, 1);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // acceptance, prediction and result checking
  always @(posedge clk_i) begin
    answer_t a;
    taken <= start && !busy;
    if (start && !busy) begin
      predict_command('{cmd_i, sequence_req_i, head_i, new_tokens_i, block_mask_i, free_id_i});
    end
    if (result_valid_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        a = pending_answers.pop_front();
        if (status_o !== a.status) report_mismatch("status", status_o, a.status);
        if (phys_block_o !== a.phys) report_mismatch("phys_block", phys_block_o, a.phys);
        if (logical_block_o !== a.logical)
          report_mismatch("logical_block", logical_block_o, a.logical);
        if (block_fill_o !== a.tokens)
          report_mismatch("block_fill", block_fill_o, a.tokens);
        if (entry_valid_o !== a.entry_valid)
          report_mismatch("entry_valid", entry_valid_o, a.entry_valid);
        if (free_count_o !== a.fcnt) report_mismatch("free_count", free_count_o, a.fcnt);
        if (last_o !== a.last) report_mismatch("last", last_o, a.last);
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    command_t c;
    int r;
    if (rst_ni && (!start || taken)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        cmd_i <= c.cmd; sequence_req_i <= c.seq; head_i <= c.head;
        new_tokens_i <= c.tokens; block_mask_i <= c.mask; free_id_i <= c.fid;
        start <= 1'b1;
        r = $urandom_range(0, 99);
        gap <= (r < 6) ? $urandom_range(15, 60) : (r < 55) ? 0 : $urandom_range(1, 3);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_command(logic [1:0] op, logic [2:0] s, logic [2:0] h,
                             logic [13:0] t, logic [63:0] m, logic [11:0] f);
    command_t c;
    if (op == CMD_APPEND && min_heads[s] > gen_heads) min_heads[s] = gen_heads;
    // keep gathers away from entries that a later head increase left unwritten
    if (op == CMD_GATHER && h < gen_heads && h >= min_heads[s])
      h = $urandom_range(0, min_heads[s] - 1);
    c = '{op, s, h, t, m, f};
    cmd_queue = {cmd_queue, c};
  endtask

  task automatic add_random(int count);
    int r;
    logic [13:0] t;
    logic [63:0] m;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 300);
      case ($urandom_range(0, 3))
        0: m = '1;
        1: m = {32'd0, $urandom};
        default: m = {$urandom, $urandom};
      endcase
      if (r < 40) add_command(CMD_APPEND, $urandom_range(0, 7), 0, t, m, $urandom);
      else if (r < 75)
        add_command(CMD_GATHER, $urandom_range(0, 7), $urandom_range(0, 7), t, m, $urandom);
      else if (r < 95) add_command(CMD_FREE, $urandom, $urandom, t, m, $urandom);
      else add_command(2'd3, $urandom, $urandom, $urandom, m, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || start || pending_answers.size() > 0 || busy)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_SEQS) cfg_seqs = val; else cfg_heads = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_phase(logic [3:0] s, logic [3:0] h);
    wait_drained();
    write_register(REG_SEQS, s);
    write_register(REG_HEADS, h);
    gen_seqs = eff(s);
    gen_heads = eff(h);
  endtask

  initial begin
    for (int i = 0; i < PHYS_BLOCKS; i++) free_stk[i] = i;
    for (int i = 0; i < MAX_SEQS; i++) begin
      seq_len[i] = 0;
      min_heads[i] = 8;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: full stack, unknown op, empty gathers, block boundaries, length limit
    add_command(CMD_FREE, 0, 0, 0, 0, 12'd4095);
    add_command(2'd3, 7, 7, 14'h3fff, '1, 12'hfff);
    add_command(CMD_GATHER, 0, 0, 0, '1, 0);
    add_command(CMD_APPEND, 0, 0, 0, 0, 0);
    add_command(CMD_APPEND, 0, 0, 1, 0, 0);
    add_command(CMD_APPEND, 0, 0, 127, 0, 0);
    add_command(CMD_APPEND, 0, 0, 1, 0, 0);
    add_command(CMD_GATHER, 0, 7, 0, '1, 0);
    add_command(CMD_GATHER, 0, 0, 0, 64'h8000_0000_0000_0000, 0);
    add_command(CMD_APPEND, 7, 0, 14'd8192, 0, 0);
    add_command(CMD_APPEND, 7, 0, 1, 0, 0);
    add_command(CMD_APPEND, 6, 0, 14'h3fff, 0, 0);
    add_command(CMD_GATHER, 7, 3, 0, '1, 0);
    add_command(CMD_GATHER, 7, 5, 0, 64'h5555_5555_5555_5555, 0);
    add_command(CMD_FREE, 0, 0, 0, 0, 12'd0);
    add_command(CMD_FREE, 0, 0, 0, 0, 12'hfff);
    add_command(CMD_FREE, 0, 0, 0, 0, 12'haaa);
    add_command(CMD_APPEND, 1, 0, 14'd200, 0, 0);
    add_random(40);

    set_phase(4'd0, 4'd15);
    add_command(CMD_APPEND, 1, 0, 5, 0, 0);
    add_command(CMD_GATHER, 1, 0, 0, '1, 0);
    add_random(40);
    set_phase(4'd3, 4'd2);
    add_command(CMD_APPEND, 3, 0, 5, 0, 0);
    add_command(CMD_GATHER, 2, 2, 0, '1, 0);
    add_random(50);
    set_phase(4'd8, 4'd1);
    add_random(50);
    set_phase(4'd5, 4'd4);
    add_random(50);
    set_phase(4'd15, 4'd0);
    add_random(50);
    set_phase(4'd8, 4'd8);
    add_random(40);

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
